// ===== rtl/core/grtl_pkg.sv =====
// Shared types and codes for the glyph range table lookup.
package grtl_pkg;

    typedef enum logic [1:0] {
        REQ_WR_RANGE  = 2'd0,
        REQ_WR_RECORD = 2'd1,
        REQ_LOOKUP    = 2'd2,
        REQ_IDLE      = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_MISS   = 2'd1,
        ST_BEYOND = 2'd2
    } status_t;

    // Item payload carried down the range chain.
    typedef struct packed {
        req_t        req;
        logic [7:0]  idx;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [31:0] value;
        logic [7:0]  ch;
    } tok_t;

    // Walk control that travels with each item.
    typedef struct packed {
        logic valid;
        logic done;
        logic found;
    } flag_t;

endpackage

// ===== rtl/core/grtl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module grtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/grtl_cell.sv =====
// One range slot of the chain: holds its bounds and steps the walk of a passing item.
module grtl_cell #(
    parameter int CELL_IDX = 0,
    parameter int SUM_W    = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  grtl_pkg::tok_t      in_tok,
    input  grtl_pkg::flag_t     in_flg,
    input  logic [SUM_W-1:0]    in_skip,
    output grtl_pkg::tok_t      out_tok,
    output grtl_pkg::flag_t     out_flg,
    output logic [SUM_W-1:0]    out_skip
);

    logic [7:0]       lo_reg;
    logic [7:0]       hi_reg;
    grtl_pkg::tok_t   tok_reg;
    grtl_pkg::flag_t  flg_reg;
    grtl_pkg::flag_t  flg_next;
    logic [SUM_W-1:0] skip_reg;
    logic [SUM_W-1:0] skip_next;
    logic [7:0]       ch_delta;
    logic [8:0]       span;
    logic             wr_hit;

    assign ch_delta = in_tok.ch - lo_reg;
    assign span     = {1'b0, hi_reg} - {1'b0, lo_reg} + 9'd1;
    assign wr_hit   = advance && in_flg.valid && (in_tok.req == grtl_pkg::REQ_WR_RANGE)
                      && (in_tok.idx == 8'(CELL_IDX));

    always_comb
    begin
        flg_next  = in_flg;
        skip_next = in_skip;
        if (in_flg.valid && (in_tok.req == grtl_pkg::REQ_LOOKUP) && !in_flg.done)
        begin
            if (lo_reg == 8'd0)
            begin
                // end of table: stop the walk without a match
                flg_next.done = 1'b1;
            end
            else if (hi_reg >= lo_reg)
            begin
                if ((in_tok.ch >= lo_reg) && (in_tok.ch <= hi_reg))
                begin
                    skip_next      = in_skip + SUM_W'(ch_delta);
                    flg_next.found = 1'b1;
                    flg_next.done  = 1'b1;
                end
                else
                begin
                    skip_next = in_skip + SUM_W'(span);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= '0;
            hi_reg  <= '0;
            flg_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                flg_reg <= flg_next;
            end
            if (wr_hit)
            begin
                lo_reg <= in_tok.lo;
                hi_reg <= in_tok.hi;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg  <= in_tok;
            skip_reg <= skip_next;
        end
    end

    assign out_tok  = tok_reg;
    assign out_flg  = flg_reg;
    assign out_skip = skip_reg;

endmodule

// ===== rtl/core/glyph_range_table_lookup_top.sv =====
// Each item passes through the MAX_RANGES range cells, then the registered output stage, to result valid.
// Throughput: one item per cycle while no result waits on out_ready; each range cell steps every item in flight once,
// and the record store is read or written in the stage after the last cell.
// The whole pipe holds while a result waits on out_ready.
// Reset clears the range table and all valid flags; the record store is not initialized.
module glyph_range_table_lookup_top #(
    parameter int MAX_RANGES = 16,
    parameter int MAX_GLYPHS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  range_low,
    input  logic [7:0]  range_high,
    input  logic [31:0] record_value,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] glyph_record,
    output logic [7:0]  glyph_offset,
    output logic [1:0]  lookup_status
);

    localparam int SUM_W = $clog2(MAX_RANGES * 256);
    localparam int GA_W  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CMP_W = ((SUM_W > GA_W) ? SUM_W : GA_W) + 2;

    grtl_pkg::tok_t   tok_chain  [MAX_RANGES+1];
    grtl_pkg::flag_t  flg_chain  [MAX_RANGES+1];
    logic [SUM_W-1:0] skip_chain [MAX_RANGES+1];

    logic advance;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    assign tok_chain[0].req   = grtl_pkg::req_t'(req_type);
    assign tok_chain[0].idx   = entry_index;
    assign tok_chain[0].lo    = range_low;
    assign tok_chain[0].hi    = range_high;
    assign tok_chain[0].value = record_value;
    assign tok_chain[0].ch    = char_code;
    assign flg_chain[0].valid = in_valid;
    assign flg_chain[0].done  = 1'b0;
    assign flg_chain[0].found = 1'b0;
    assign skip_chain[0]      = '0;

    for (genvar k = 0; k < MAX_RANGES; k++)
    begin : g_cell
        grtl_cell #(
            .CELL_IDX (k),
            .SUM_W    (SUM_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_tok   (tok_chain[k]),
            .in_flg   (flg_chain[k]),
            .in_skip  (skip_chain[k]),
            .out_tok  (tok_chain[k+1]),
            .out_flg  (flg_chain[k+1]),
            .out_skip (skip_chain[k+1])
        );
    end

    // Tail of the chain: record store access and result fields.
    grtl_pkg::tok_t    t_tok;
    grtl_pkg::flag_t   t_flg;
    logic [SUM_W-1:0]  t_ofs;
    logic              beyond;
    logic              rec_idx_ok;
    logic              range_idx_ok;
    logic              ram_we;
    logic              ram_re;
    logic [GA_W-1:0]   ram_raddr;
    logic [31:0]       ram_rdata;

    logic                 out_valid_reg;
    logic                 use_rec_reg;
    logic                 use_rec_next;
    logic [7:0]           offset_reg;
    logic [7:0]           offset_next;
    grtl_pkg::status_t    status_reg;
    grtl_pkg::status_t    status_next;

    assign t_tok = tok_chain[MAX_RANGES];
    assign t_flg = flg_chain[MAX_RANGES];
    assign t_ofs = skip_chain[MAX_RANGES];

    assign beyond       = t_flg.found && (CMP_W'(t_ofs) >= CMP_W'(MAX_GLYPHS));
    assign rec_idx_ok   = CMP_W'(t_tok.idx) < CMP_W'(MAX_GLYPHS);
    assign range_idx_ok = CMP_W'(t_tok.idx) < CMP_W'(MAX_RANGES);

    assign ram_we    = advance && t_flg.valid && (t_tok.req == grtl_pkg::REQ_WR_RECORD)
                       && rec_idx_ok;
    assign ram_re    = advance && t_flg.valid && (t_tok.req == grtl_pkg::REQ_LOOKUP);
    assign ram_raddr = (t_flg.found && !beyond) ? GA_W'(t_ofs) : '0;

    grtl_ram #(
        .WIDTH (32),
        .DEPTH (MAX_GLYPHS)
    ) u_records (
        .clk   (clk),
        .we    (ram_we),
        .waddr (GA_W'(t_tok.idx)),
        .wdata (t_tok.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        use_rec_next = 1'b0;
        offset_next  = 8'd0;
        status_next  = grtl_pkg::ST_FOUND;
        unique case (t_tok.req)
            grtl_pkg::REQ_WR_RANGE:
            begin
                if (!range_idx_ok)
                begin
                    status_next = grtl_pkg::ST_BEYOND;
                end
            end
            grtl_pkg::REQ_WR_RECORD:
            begin
                if (!rec_idx_ok)
                begin
                    status_next = grtl_pkg::ST_BEYOND;
                end
            end
            grtl_pkg::REQ_LOOKUP:
            begin
                if (!t_flg.found)
                begin
                    // miss returns the record at slot zero
                    use_rec_next = 1'b1;
                    status_next  = grtl_pkg::ST_MISS;
                end
                else if (beyond)
                begin
                    offset_next = t_ofs[7:0];
                    status_next = grtl_pkg::ST_BEYOND;
                end
                else
                begin
                    use_rec_next = 1'b1;
                    offset_next  = t_ofs[7:0];
                end
            end
            default:
            begin
                status_next = grtl_pkg::ST_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= t_flg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            use_rec_reg <= use_rec_next;
            offset_reg  <= offset_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign glyph_record  = use_rec_reg ? ram_rdata : 32'd0;
    assign glyph_offset  = offset_reg;
    assign lookup_status = status_reg;

endmodule

// ===== test/glyph_range_table_lookup_checker.sv =====
// Result checker for the glyph range table lookup: predicts each transfer and compares.
`timescale 1ns / 100ps
module glyph_range_table_lookup_checker #(
    parameter int MAX_RANGES = 16,
    parameter int MAX_GLYPHS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  range_low,
    input  logic [7:0]  range_high,
    input  logic [31:0] record_value,
    input  logic [7:0]  char_code,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] glyph_record,
    input  logic [7:0]  glyph_offset,
    input  logic [1:0]  lookup_status,
    output int          mismatch_count,
    output int          outstanding
);
    import grtl_pkg::*;

    typedef struct {
        logic [31:0] rec;
        logic [7:0]  ofs;
        status_t     st;
    } glyph_result_t;

    glyph_result_t expected_results[$];
    logic [7:0]    range_lo_table[MAX_RANGES];
    logic [7:0]    range_hi_table[MAX_RANGES];
    logic [31:0]   record_table[MAX_GLYPHS];

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Update the table copy and queue the result this request should produce.
    task automatic predict_request();
        glyph_result_t res;
        int unsigned   skip;
        int unsigned   ofs;
        bit            hit;
        bit            stop;
        res.rec = '0;
        res.ofs = '0;
        res.st  = ST_FOUND;
        skip    = 0;
        ofs     = 0;
        hit     = 1'b0;
        stop    = 1'b0;
        case (req_t'(req_type))
            REQ_WR_RANGE:
                if (entry_index < MAX_RANGES)
                begin
                    range_lo_table[entry_index] = range_low;
                    range_hi_table[entry_index] = range_high;
                end
                else
                    res.st = ST_BEYOND;
            REQ_WR_RECORD:
                if (entry_index < MAX_GLYPHS)
                    record_table[entry_index] = record_value;
                else
                    res.st = ST_BEYOND;
            REQ_LOOKUP:
            begin
                for (int i = 0; i < MAX_RANGES; i++)
                begin
                    if (!stop && range_lo_table[i] == 8'd0)
                        stop = 1'b1;
                    else if (!stop && range_hi_table[i] >= range_lo_table[i])
                    begin
                        if (char_code >= range_lo_table[i] && char_code <= range_hi_table[i])
                        begin
                            ofs  = skip + char_code - range_lo_table[i];
                            hit  = 1'b1;
                            stop = 1'b1;
                        end
                        else
                            skip += range_hi_table[i] - range_lo_table[i] + 1;
                    end
                end
                if (!hit)
                begin
                    res.rec = record_table[0];
                    res.st  = ST_MISS;
                end
                else if (ofs >= MAX_GLYPHS)
                begin
                    res.ofs = ofs[7:0];
                    res.st  = ST_BEYOND;
                end
                else
                begin
                    res.rec = record_table[ofs];
                    res.ofs = ofs[7:0];
                end
            end
            default: ;
        endcase
        expected_results.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        glyph_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                range_lo_table[i] = '0;
                range_hi_table[i] = '0;
            end
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h %0h %0h",
                             $time, glyph_record, glyph_offset, lookup_status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (glyph_record !== want.rec)
                        report_mismatch("glyph_record", want.rec, glyph_record);
                    if (glyph_offset !== want.ofs)
                        report_mismatch("glyph_offset", want.ofs, glyph_offset);
                    if (lookup_status !== want.st)
                        report_mismatch("lookup_status", want.st, lookup_status);
                end
            end
            if (in_valid && in_ready)
                predict_request();
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== test/glyph_range_table_lookup_top_tb.sv =====
// Testbench top for the glyph range table lookup: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module glyph_range_table_lookup_top_tb;
    import grtl_pkg::*;

    localparam int MAX_RANGES   = 16;
    localparam int MAX_GLYPHS   = 256;
    localparam int RANDOM_ITEMS = 460;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [7:0]  entry_index;
    logic [7:0]  range_low;
    logic [7:0]  range_high;
    logic [31:0] record_value;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] glyph_record;
    logic [7:0]  glyph_offset;
    logic [1:0]  lookup_status;

    int mismatch_count;
    int outstanding;
    int sent_items     = 0;
    int send_idle_pct  = 31;
    int recv_stall_pct = 77;
    int cycle_count    = 0;

    glyph_range_table_lookup_top #(
        .MAX_RANGES(MAX_RANGES),
        .MAX_GLYPHS(MAX_GLYPHS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .range_low    (range_low),
        .range_high   (range_high),
        .record_value (record_value),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .glyph_record (glyph_record),
        .glyph_offset (glyph_offset),
        .lookup_status(lookup_status)
    );

    glyph_range_table_lookup_checker #(
        .MAX_RANGES(MAX_RANGES),
        .MAX_GLYPHS(MAX_GLYPHS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .entry_index   (entry_index),
        .range_low     (range_low),
        .range_high    (range_high),
        .record_value  (record_value),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .glyph_record  (glyph_record),
        .glyph_offset  (glyph_offset),
        .lookup_status (lookup_status),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive one request after a random gap and hold it until the transfer.
    task automatic issue_request(input req_t req, input logic [7:0] idx,
                                 input logic [7:0] lo, input logic [7:0] hi,
                                 input logic [31:0] val, input logic [7:0] ch);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        entry_index  <= idx;
        range_low    <= lo;
        range_high   <= hi;
        record_value <= val;
        char_code    <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic write_range(input logic [7:0] slot, input logic [7:0] lo,
                               input logic [7:0] hi);
        issue_request(REQ_WR_RANGE, slot, lo, hi, $urandom(), 8'($urandom()));
    endtask

    task automatic write_record(input logic [7:0] slot, input logic [31:0] val);
        issue_request(REQ_WR_RECORD, slot, 8'($urandom()), 8'($urandom()), val,
                      8'($urandom()));
    endtask

    task automatic lookup_char(input logic [7:0] ch);
        issue_request(REQ_LOOKUP, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                      $urandom(), ch);
    endtask

    initial
    begin : stimulus
        int unsigned n_ranges;
        int unsigned n_looks;
        int unsigned pick;
        int unsigned mode;
        int          rand_base;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  ep_lo[MAX_RANGES];
        logic [7:0]  ep_hi[MAX_RANGES];

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_IDLE;
        entry_index  = '0;
        range_low    = '0;
        range_high   = '0;
        record_value = '0;
        char_code    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill every record slot so no lookup can land on an unwritten one.
        for (int s = 0; s < MAX_GLYPHS; s++)
            write_record(8'(s), (s == 0) ? 32'hFFFF_FFFF :
                                (s == MAX_GLYPHS - 1) ? 32'h0 : $urandom());

        // Empty table, idle request, out-of-range slots.
        lookup_char(8'd65);
        lookup_char(8'd0);
        issue_request(REQ_IDLE, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        write_range(8'(MAX_RANGES), 8'd5, 8'd9);
        write_range(8'd255, 8'd5, 8'd9);

        // Small table with an inverted entry and a single-code range at the top.
        write_range(8'd0, 8'd1, 8'd10);
        write_range(8'd1, 8'd20, 8'd10);
        write_range(8'd2, 8'd255, 8'd255);
        write_range(8'd3, 8'd0, 8'd77);
        lookup_char(8'd1);
        lookup_char(8'd10);
        lookup_char(8'd15);
        lookup_char(8'd255);
        lookup_char(8'd0);
        lookup_char(8'd20);

        // Overlapping wide ranges push later offsets past the record store.
        write_range(8'd0, 8'd1, 8'd200);
        write_range(8'd1, 8'd1, 8'd100);
        write_range(8'd2, 8'd201, 8'd255);
        lookup_char(8'd201);
        lookup_char(8'd255);
        lookup_char(8'd200);

        rand_base = sent_items;
        while (sent_items - rand_base < RANDOM_ITEMS)
        begin
            case ((sent_items - rand_base) / (RANDOM_ITEMS / 3))
                0:
                begin
                    send_idle_pct  = 31;
                    recv_stall_pct = 77;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 31;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            // Build a table from slot 0, mostly terminated, then look up codes in it.
            n_ranges = $urandom_range(0, MAX_RANGES);
            for (int s = 0; s < n_ranges; s++)
            begin
                lo   = 8'($urandom_range(1, 255));
                mode = $urandom_range(9);
                if (mode < 6)
                    hi = (lo > 8'd240) ? 8'd255 : lo + 8'($urandom_range(0, 15));
                else if (mode < 9)
                    hi = 8'($urandom_range(lo, 255));
                else
                    hi = 8'($urandom_range(0, lo - 1));
                ep_lo[s] = lo;
                ep_hi[s] = hi;
                write_range(8'(s), lo, hi);
            end
            if (n_ranges < MAX_RANGES && $urandom_range(3) != 0)
                write_range(8'(n_ranges), 8'd0, 8'($urandom()));

            n_looks = $urandom_range(4, 12);
            for (int k = 0; k < n_looks; k++)
            begin
                mode = $urandom_range(19);
                if (mode == 0)
                    write_record(8'($urandom()), $urandom());
                else if (mode == 1)
                    write_range(8'($urandom_range(MAX_RANGES, 255)), 8'($urandom()),
                                8'($urandom()));
                else if (mode == 2)
                    issue_request(REQ_IDLE, 8'($urandom()), 8'($urandom()),
                                  8'($urandom()), $urandom(), 8'($urandom()));
                else if (mode < 16 && n_ranges > 0)
                begin
                    pick = $urandom_range(0, n_ranges - 1);
                    if (ep_hi[pick] >= ep_lo[pick])
                        lookup_char(8'($urandom_range(ep_lo[pick], ep_hi[pick])));
                    else
                        lookup_char(8'($urandom()));
                end
                else
                    lookup_char(8'($urandom()));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        wait (outstanding == 0);
        // hold for stray results past the pipe depth
        repeat (MAX_RANGES + 10) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
